/* hdl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial hash values and the SHA-256
// mixing functions used by the hasher and its channel interfaces.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  word_idx_t;

  // Initial hash values, chaining word 0 first.
  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants, round 0 first.
  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // First padding byte after the message.
  localparam byte_t PAD_BYTE = 8'h80;

  // Byte position where the 64-bit length field starts.
  localparam logic [5:0] LEN_POS = 6'd56;

  // Compression functions on the working variables.
  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Message schedule functions.
  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

/* hdl/sha256_in_if.sv */
// ----------------------------------------------------------------------------
// SHA-256 message channel
// Valid/ready channel that carries one message byte or end mark per
// transaction.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic                valid;
  logic                ready;
  sha256_pkg::byte_t   msg_byte;
  logic                byte_present;
  logic                end_of_message;

  modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

/* hdl/sha256_out_if.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest channel
// Valid/ready channel that carries one digest word per transaction.
// ----------------------------------------------------------------------------
interface sha256_out_if;
  logic                    valid;
  logic                    ready;
  sha256_pkg::word_t       digest_word;
  sha256_pkg::word_idx_t   word_index;
  logic                    final_word;

  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

/* hdl/sha256_message_hasher_unit.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Packs message bytes into 512-bit blocks, compresses them with a single
// shared round unit, pads the message and streams out the 256-bit digest.
// ----------------------------------------------------------------------------
// The block takes one byte per transaction and accepts a new byte on every
// cycle while a block is filling. When the 64th byte of a block arrives the
// block is compressed by one round unit that runs one round per cycle, and
// the input is held off through the 64 rounds and the fold of the working
// variables into the chaining words, so the hasher cannot take a byte of the
// next block until that compression is through. An end-of-message transaction
// costs one padding step and one compression, or two padding steps and two
// compressions when fewer than nine bytes of room remain in the last block,
// and is followed by eight digest transactions, word 0 first, the last one
// flagged with final_word. The input is not ready until the last digest word
// has been taken; the hasher then starts over with a fresh message.
module sha256_message_hasher_unit (
  input  logic               clk,
  input  logic               rst,
  sha256_in_if.sink          msg,
  sha256_out_if.source       digest
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // What follows a compression.
  localparam logic [1:0] AFT_IDLE = 2'd0;
  localparam logic [1:0] AFT_PAD  = 2'd1;
  localparam logic [1:0] AFT_ZERO = 2'd2;
  localparam logic [1:0] AFT_OUT  = 2'd3;

  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam sha256_pkg::word_idx_t LAST_WORD = 3'd7;

  logic [2:0]              state;
  logic [1:0]              after;
  logic [5:0]              round;
  logic [5:0]              pos;
  logic [63:0]             bit_len;
  sha256_pkg::word_idx_t   out_idx;
  sha256_pkg::word_t       h [8];
  sha256_pkg::word_t       v [8];
  sha256_pkg::word_t       w [16];

  logic                    in_acc;
  logic                    out_acc;
  logic                    start_cmp;
  sha256_pkg::word_t       t1;
  sha256_pkg::word_t       t2;
  sha256_pkg::word_t       w_new;
  sha256_pkg::word_t       pad_block [16];
  logic [5:0]              p;

  // Handshakes.
  assign in_acc  = msg.valid && msg.ready;
  assign out_acc = digest.valid && digest.ready;

  assign msg.ready          = (state == S_IDLE);
  assign digest.valid       = (state == S_OUT);
  assign digest.digest_word = h[0];
  assign digest.word_index  = out_idx;
  assign digest.final_word  = (out_idx == LAST_WORD);

  // A compression starts on a full block, after padding, or on the zero block.
  assign start_cmp = (state == S_IDLE && in_acc && msg.byte_present && pos == LAST_BYTE) ||
                     state == S_PAD || state == S_ZERO;

  // Shared round unit and schedule expansion.
  always_comb begin
    t1 = v[7] + sha256_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
         sha256_pkg::K[round] + w[0];
    t2 = sha256_pkg::big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = sha256_pkg::small_sigma1(w[14]) + w[9] + sha256_pkg::small_sigma0(w[1]) + w[0];
  end

  // Padding: the 0x80 byte at the current position, zeros after it.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        p = 6'(i * 4 + j);
        if (p == pos) begin
          pad_block[i][8*(3-j) +: 8] = sha256_pkg::PAD_BYTE;
        end else if (p > pos) begin
          pad_block[i][8*(3-j) +: 8] = 8'h00;
        end else begin
          pad_block[i][8*(3-j) +: 8] = w[i][8*(3-j) +: 8];
        end
      end
    end
  end

  // Sequencer, chaining words and message counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      after   <= AFT_IDLE;
      round   <= '0;
      pos     <= '0;
      bit_len <= '0;
      out_idx <= '0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= sha256_pkg::IV[i];
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (msg.byte_present) begin
              bit_len <= bit_len + 64'd8;
              pos     <= pos + 6'd1;
              if (pos == LAST_BYTE) begin
                state <= S_ROUND;
                round <= '0;
                after <= msg.end_of_message ? AFT_PAD : AFT_IDLE;
              end else if (msg.end_of_message) begin
                state <= S_PAD;
              end
            end else if (msg.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          state <= S_ROUND;
          round <= '0;
          after <= (pos >= sha256_pkg::LEN_POS) ? AFT_ZERO : AFT_OUT;
        end
        S_ZERO: begin
          state <= S_ROUND;
          round <= '0;
          after <= AFT_OUT;
        end
        S_ROUND: begin
          round <= round + 6'd1;
          if (round == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          out_idx <= '0;
          case (after)
            AFT_PAD:  state <= S_PAD;
            AFT_ZERO: state <= S_ZERO;
            AFT_OUT:  state <= S_OUT;
            default:  state <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == LAST_WORD) begin
              // Digest delivered: start a new message.
              state   <= S_IDLE;
              pos     <= '0;
              bit_len <= '0;
              for (int i = 0; i < 8; i++) begin
                h[i] <= sha256_pkg::IV[i];
              end
            end else begin
              for (int i = 0; i < 7; i++) begin
                h[i] <= h[i + 1];
              end
              h[7] <= h[0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working variables and block / schedule window.
  always_ff @(posedge clk) begin
    if (start_cmp) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= h[i];
      end
    end else if (state == S_ROUND) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end

    if (state == S_IDLE && in_acc && msg.byte_present) begin
      for (int i = 0; i < 16; i++) begin
        if (pos[5:2] == 4'(i)) begin
          w[i][8*(3 - pos[1:0]) +: 8] <= msg.msg_byte;
        end
      end
    end else if (state == S_PAD) begin
      for (int i = 0; i < 14; i++) begin
        w[i] <= pad_block[i];
      end
      // The length goes into this block only when it still has room for it.
      if (pos < sha256_pkg::LEN_POS) begin
        w[14] <= bit_len[63:32];
        w[15] <= bit_len[31:0];
      end else begin
        w[14] <= pad_block[14];
        w[15] <= pad_block[15];
      end
    end else if (state == S_ZERO) begin
      for (int i = 0; i < 14; i++) begin
        w[i] <= '0;
      end
      w[14] <= bit_len[63:32];
      w[15] <= bit_len[31:0];
    end else if (state == S_ROUND) begin
      // Window slides by one word; the newest schedule word enters at the top.
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end
  end

  // The final flag marks exactly the eighth digest word.
  a_final_word: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> (digest.final_word == (digest.word_index == LAST_WORD)))
    else $error("final_word does not match word_index");

  // Digest output always starts at word 0.
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(digest.valid) |-> (digest.word_index == 3'd0))
    else $error("digest output did not start at word 0");

  // Taking the last digest word returns the hasher to a fresh message.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_acc && digest.final_word) |=> (msg.ready && bit_len == 64'd0 && pos == 6'd0))
    else $error("hasher did not restart after the digest");

  // Sixty-four rounds end in the fold-in cycle.
  a_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == LAST_ROUND) |=> (state == S_ADD))
    else $error("compression did not end after the last round");

  // No new input while a digest is pending.
  a_no_input_out: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> !msg.ready)
    else $error("input ready while the digest is pending");

endmodule
